/* hw/rtl/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] HeadFirstReset = 8'hEB;
  localparam logic [ByteW-1:0] HeadSecondReset = 8'h90;
  localparam logic [ByteW-1:0] EndFlagReset = 8'h16;

  localparam logic [CfgIdxW-1:0] CFG_HEAD_FIRST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_FLAG = 2'd2;

  localparam logic [KindW-1:0] KIND_CONTROL = 2'd0;
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KindW-1:0] KIND_STATUS = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_END = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_SUM = 2'd2;

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_HEAD2 = 8'b0000_0010,
    PH_CTL   = 8'b0000_0100,
    PH_LENLO = 8'b0000_1000,
    PH_LENHI = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CSUM  = 8'b0100_0000,
    PH_END   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   data_byte;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    frame_length;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/serial_frame_receiver_core.sv */
// Serial frame receiver core.
// Input channel: in_valid / in_stall carry one received byte (in_byte) per word.
// Output channel: out_valid / out_stall carry one result word: kind, data_byte,
// status, frame_length and last. Control and payload bytes go out as words of
// their own; the end flag byte closes the frame with a status word (last = 1).
// Head, length and checksum bytes produce no output word.
// Throughput: one byte per cycle while in_stall is low. Each byte is decoded in
// the cycle it is accepted and its result is registered in the single output
// register, or in the skid register while the output stalls.
// When the receiver stalls, one more result is held in a skid register; while
// the skid register is full, in_stall is high. in_stall is a register output.
// Configuration: cfg_write with cfg_index 0 (first head byte), 1 (second head
// byte), 2 (end flag byte) and cfg_data; index 3 is ignored.
// Reset (rst, synchronous, active high) returns the registers to 0xEB, 0x90
// and 0x16, clears both output stages and starts hunting for the first head.
`default_nettype none

module serial_frame_receiver_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [sfr_pkg::ByteW-1:0]    in_byte,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [sfr_pkg::KindW-1:0]    kind,
  output logic [sfr_pkg::ByteW-1:0]    data_byte,
  output logic [sfr_pkg::StatusW-1:0]  status,
  output logic [sfr_pkg::LenW-1:0]     frame_length,
  output logic                         last,
  input  wire                          cfg_write,
  input  wire  [sfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [sfr_pkg::ByteW-1:0]    cfg_data
);
  import sfr_pkg::*;

  logic [ByteW-1:0] head_first;
  logic [ByteW-1:0] head_second;
  logic [ByteW-1:0] close_byte;

  phase_t           phase;
  phase_t           phase_next;
  logic [LenW-1:0]  payload_length;
  logic [LenW-1:0]  payload_length_next;
  logic [LenW-1:0]  bytes_left;
  logic [LenW-1:0]  bytes_left_next;
  logic [ByteW-1:0] running_sum;
  logic [ByteW-1:0] running_sum_next;
  logic             checksum_matched;
  logic             checksum_matched_next;

  logic             accept;
  logic             res_valid;
  result_t          res;
  logic [ByteW-1:0] sum_add;
  logic [LenW-1:0]  len_full;
  logic [LenW-1:0]  bytes_left_dec;

  result_t          out_reg;
  result_t          skid;
  logic             skid_valid;
  logic             out_take;

  assign accept = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  assign sum_add = running_sum + in_byte;
  assign len_full = {in_byte, payload_length[ByteW-1:0]};
  assign bytes_left_dec = bytes_left - LenW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_first <= HeadFirstReset;
      head_second <= HeadSecondReset;
      close_byte <= EndFlagReset;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HEAD_FIRST:  head_first <= cfg_data;
        CFG_HEAD_SECOND: head_second <= cfg_data;
        CFG_END_FLAG:    close_byte <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    payload_length_next = payload_length;
    bytes_left_next = bytes_left;
    running_sum_next = running_sum;
    checksum_matched_next = checksum_matched;
    res_valid = 1'b0;
    res = '0;
    case (phase)
      PH_HUNT: begin
        if (in_byte == head_first) begin
          running_sum_next = in_byte;
          phase_next = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        if (in_byte == head_second) begin
          running_sum_next = sum_add;
          phase_next = PH_CTL;
        end else if (in_byte == head_first) begin
          running_sum_next = in_byte;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_CTL: begin
        running_sum_next = sum_add;
        phase_next = PH_LENLO;
        res_valid = 1'b1;
        res.kind = KIND_CONTROL;
        res.data_byte = in_byte;
      end
      PH_LENLO: begin
        running_sum_next = sum_add;
        payload_length_next = {{(LenW-ByteW){1'b0}}, in_byte};
        phase_next = PH_LENHI;
      end
      PH_LENHI: begin
        running_sum_next = sum_add;
        payload_length_next = len_full;
        bytes_left_next = len_full;
        phase_next = (len_full == '0) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        running_sum_next = sum_add;
        bytes_left_next = bytes_left_dec;
        if (bytes_left_dec == '0) phase_next = PH_CSUM;
        res_valid = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.data_byte = in_byte;
      end
      PH_CSUM: begin
        checksum_matched_next = (in_byte == running_sum);
        phase_next = PH_END;
      end
      PH_END: begin
        res_valid = 1'b1;
        res.kind = KIND_STATUS;
        res.frame_length = payload_length;
        res.last = 1'b1;
        if (in_byte != close_byte) res.status = STATUS_BAD_END;
        else if (!checksum_matched) res.status = STATUS_BAD_SUM;
        else res.status = STATUS_OK;
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      payload_length <= '0;
      bytes_left <= '0;
      running_sum <= '0;
      checksum_matched <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      payload_length <= payload_length_next;
      bytes_left <= bytes_left_next;
      running_sum <= running_sum_next;
      checksum_matched <= checksum_matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || out_take) begin
        out_reg <= res;
        out_valid <= 1'b1;
      end else begin
        skid <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign kind = out_reg.kind;
  assign data_byte = out_reg.data_byte;
  assign status = out_reg.status;
  assign frame_length = out_reg.frame_length;
  assign last = out_reg.last;

endmodule

`default_nettype wire

/* hw/rtl/sfr_checker.sv */
`default_nettype none

module sfr_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [sfr_pkg::KindW-1:0]     kind,
  input wire [sfr_pkg::ByteW-1:0]     data_byte,
  input wire [sfr_pkg::StatusW-1:0]   status,
  input wire [sfr_pkg::LenW-1:0]      frame_length,
  input wire                          last
);
  import sfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(status) && $stable(frame_length) && $stable(last))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_STATUS)))
    else $error("last does not mark the status word");

  a_byte_word_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_STATUS |-> status == STATUS_OK && frame_length == '0
      && (kind == KIND_CONTROL || kind == KIND_PAYLOAD))
    else $error("byte word carries status fields");

  a_status_word_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> data_byte == '0
      && (status == STATUS_OK || status == STATUS_BAD_END || status == STATUS_BAD_SUM))
    else $error("malformed status word");

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .kind(kind),
  .data_byte(data_byte),
  .status(status),
  .frame_length(frame_length),
  .last(last)
);

`default_nettype wire
